@@ design/buddy_memory_allocator_defines.svh @@
// Assertion macros used by the allocator datapath.
`ifndef BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH
`define BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bma_pkg.sv @@
package bma_pkg;

    localparam int TOTAL_LOG2 = 10;
    localparam int NODE_COUNT = (2 << TOTAL_LOG2) - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LVL_W      = 4;

    // Tree node codes.
    typedef enum logic [1:0] {
        NODE_ABSENT = 2'd0,
        NODE_FREE   = 2'd1,
        NODE_SPLIT  = 2'd2,
        NODE_ALLOC  = 2'd3
    } t_node;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [10:0] request_size;
        logic [9:0]  free_address;
    } t_bma_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_address;
        logic [10:0] block_units;
    } t_bma_out;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLR,
        CMD_LOAD,
        CMD_SCAN_INIT,
        CMD_FREE_INIT,
        CMD_RD_NODE,
        CMD_NEXT,
        CMD_WR_SPLIT,
        CMD_WR_LEFT,
        CMD_WR_RIGHT,
        CMD_WR_ALLOC,
        CMD_WR_FREE,
        CMD_RD_BUDDY,
        CMD_WR_ABS_NODE,
        CMD_WR_ABS_BUDDY,
        CMD_WR_PARENT,
        CMD_SET_NOSPACE,
        CMD_SET_BADFREE,
        CMD_OUT
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic op_free;
        logic too_big;
        logic misalign;
        logic rd_free;
        logic rd_alloc;
        logic last_in_level;
        logic top_level;
        logic at_depth;
        logic at_root;
        logic out_busy;
    } t_dp_status;

    // Log2 of the request rounded up to a power of two; zero counts as one.
    function automatic logic [LVL_W-1:0] size_log2(input logic [10:0] req);
        logic [LVL_W-1:0] k;
        k = LVL_W'(11);
        for (int j = 11; j >= 0; j--) begin
            if ((12'd1 << j) >= {1'b0, req}) begin
                k = LVL_W'(j);
            end
        end
        return k;
    endfunction

    // Heap index of the first node on a tree level.
    function automatic logic [NODE_W-1:0] level_first(input logic [LVL_W-1:0] d);
        return NODE_W'((32'd1 << d) - 32'd1);
    endfunction

endpackage

@@ design/bma_datapath.sv @@
`include "buddy_memory_allocator_defines.svh"

module bma_datapath import bma_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_bma_in    i_in_data,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_bma_out   o_out_data
);

    t_node              r_mem [NODE_COUNT];
    t_node              r_rdata;
    logic               r_op;
    logic [LVL_W-1:0]   r_k;
    logic [9:0]         r_addr;
    t_status            r_st;
    logic [NODE_W-1:0]  r_node;
    logic [LVL_W-1:0]   r_d;
    logic [9:0]         r_i;
    logic               r_out_valid;
    t_bma_out           r_out_data;

    logic               too_big;
    logic [LVL_W-1:0]   depth;
    logic [10:0]        size;
    logic [9:0]         addr_mask;
    logic [NODE_W-1:0]  buddy;
    logic [NODE_W-1:0]  parent;
    logic [NODE_W-1:0]  left;
    logic [20:0]        alloc_wide;
    logic [9:0]         out_addr;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_addr;
    t_node              wr_data;
    logic               rd_en;
    logic [NODE_W-1:0]  rd_addr;

    // Values derived from the current request.
    assign too_big    = r_k > LVL_W'(TOTAL_LOG2);
    assign depth      = LVL_W'(TOTAL_LOG2) - r_k;
    assign size       = too_big ? 11'd0 : 11'(12'd1 << r_k);
    assign addr_mask  = 10'((32'd1 << r_k) - 32'd1);
    assign buddy      = r_node[0] ? r_node + NODE_W'(1) : r_node - NODE_W'(1);
    assign parent     = NODE_W'((r_node - NODE_W'(1)) >> 1);
    assign left       = NODE_W'({r_node, 1'b1});
    assign alloc_wide = 21'(r_i) << r_k;
    assign out_addr   = (r_op == OP_FREE) ? r_addr :
                        ((r_st == ST_OK) ? alloc_wide[9:0] : 10'd0);

    // Memory port control for each command.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = NODE_ABSENT;
        rd_en   = 1'b0;
        rd_addr = r_node;
        case (i_cmd)
            CMD_CLR: begin
                wr_en   = 1'b1;
                wr_data = (r_node == '0) ? NODE_FREE : NODE_ABSENT;
            end
            CMD_RD_NODE: begin
                rd_en = 1'b1;
            end
            CMD_RD_BUDDY: begin
                rd_en   = 1'b1;
                rd_addr = buddy;
            end
            CMD_WR_SPLIT: begin
                wr_en   = 1'b1;
                wr_data = NODE_SPLIT;
            end
            CMD_WR_LEFT: begin
                wr_en   = 1'b1;
                wr_addr = left;
                wr_data = NODE_FREE;
            end
            CMD_WR_RIGHT: begin
                wr_en   = 1'b1;
                wr_addr = left + NODE_W'(1);
                wr_data = NODE_FREE;
            end
            CMD_WR_ALLOC: begin
                wr_en   = 1'b1;
                wr_data = NODE_ALLOC;
            end
            CMD_WR_FREE: begin
                wr_en   = 1'b1;
                wr_data = NODE_FREE;
            end
            CMD_WR_ABS_NODE: begin
                wr_en = 1'b1;
            end
            CMD_WR_ABS_BUDDY: begin
                wr_en   = 1'b1;
                wr_addr = buddy;
            end
            CMD_WR_PARENT: begin
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_data = NODE_FREE;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Node store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Request registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op   <= i_in_data.operation;
                r_k    <= size_log2(i_in_data.request_size);
                r_addr <= i_in_data.free_address;
                r_st   <= ST_OK;
            end
            CMD_SET_NOSPACE: begin
                r_st <= ST_NO_SPACE;
            end
            CMD_SET_BADFREE: begin
                r_st <= ST_BAD_FREE;
            end
            CMD_SCAN_INIT: begin
                r_d <= depth;
                r_i <= '0;
            end
            CMD_NEXT: begin
                if (r_i == 10'((32'd1 << r_d) - 32'd1)) begin
                    r_d <= r_d - LVL_W'(1);
                    r_i <= '0;
                end else begin
                    r_i <= r_i + 10'd1;
                end
            end
            CMD_WR_RIGHT: begin
                r_d <= r_d + LVL_W'(1);
                r_i <= {r_i[8:0], 1'b0};
            end
            default: begin
                r_d <= r_d;
            end
        endcase
    end

    // Node pointer, which also counts the clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
        end else begin
            case (i_cmd)
                CMD_CLR:       r_node <= r_node + NODE_W'(1);
                CMD_SCAN_INIT: r_node <= level_first(depth);
                CMD_FREE_INIT: r_node <= level_first(depth) + NODE_W'(r_addr >> r_k);
                CMD_NEXT: begin
                    if (r_i == 10'((32'd1 << r_d) - 32'd1)) begin
                        r_node <= level_first(r_d - LVL_W'(1));
                    end else begin
                        r_node <= r_node + NODE_W'(1);
                    end
                end
                CMD_WR_RIGHT:  r_node <= left;
                CMD_WR_PARENT: r_node <= parent;
                default:       r_node <= r_node;
            endcase
        end
    end

    // Output register; it holds its transaction while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_OUT) begin
            r_out_data.status        <= r_st;
            r_out_data.block_address <= out_addr;
            r_out_data.block_units   <= size;
        end
    end

    // Status flags for the controller.
    always_comb begin
        o_status.clr_done      = r_node == NODE_W'(NODE_COUNT - 1);
        o_status.op_free       = r_op == OP_FREE;
        o_status.too_big       = too_big;
        o_status.misalign      = |(r_addr & addr_mask);
        o_status.rd_free       = r_rdata == NODE_FREE;
        o_status.rd_alloc      = r_rdata == NODE_ALLOC;
        o_status.last_in_level = r_i == 10'((32'd1 << r_d) - 32'd1);
        o_status.top_level     = r_d == '0;
        o_status.at_depth      = r_d == depth;
        o_status.at_root       = r_node == '0;
        o_status.out_busy      = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `BMA_ASSERT_SAME(a_out_from_cmd, i_clk, i_rst_n, r_out_valid && !$past(r_out_valid),
        $past(i_cmd) == CMD_OUT, "Result appeared without an output command")
    `BMA_ASSERT_SAME(a_out_no_overwrite, i_clk, i_rst_n, i_cmd == CMD_OUT,
        !(r_out_valid && i_out_stall), "Stalled result would be overwritten")
    `BMA_ASSERT_NEXT(a_split_moves_down, i_clk, i_rst_n, i_cmd == CMD_WR_RIGHT,
        r_d == $past(r_d) + LVL_W'(1), "Split did not descend one level")

endmodule

@@ design/bma_ctrl.sv @@
module bma_ctrl import bma_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_DISP   = 15'b000000000000100,
        S_A_RD   = 15'b000000000001000,
        S_A_CHK  = 15'b000000000010000,
        S_SP_P   = 15'b000000000100000,
        S_SP_L   = 15'b000000001000000,
        S_SP_R   = 15'b000000010000000,
        S_F_RD   = 15'b000000100000000,
        S_F_CHK  = 15'b000001000000000,
        S_F_B    = 15'b000010000000000,
        S_F_BCHK = 15'b000100000000000,
        S_M_B    = 15'b001000000000000,
        S_M_P    = 15'b010000000000000,
        S_RES    = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = r_state != S_IDLE;

    // Next state and command for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLR;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_status.op_free) begin
                    if (i_status.too_big) begin
                        o_cmd   = CMD_SET_NOSPACE;
                        n_state = S_RES;
                    end else begin
                        o_cmd   = CMD_SCAN_INIT;
                        n_state = S_A_RD;
                    end
                end else if (i_status.too_big || i_status.misalign) begin
                    o_cmd   = CMD_SET_BADFREE;
                    n_state = S_RES;
                end else begin
                    o_cmd   = CMD_FREE_INIT;
                    n_state = S_F_RD;
                end
            end
            S_A_RD: begin
                o_cmd   = CMD_RD_NODE;
                n_state = S_A_CHK;
            end
            // A free node ends the scan; else go along the level and up, or end with no space.
            S_A_CHK: begin
                if (i_status.rd_free) begin
                    n_state = S_SP_P;
                end else if (i_status.last_in_level && i_status.top_level) begin
                    o_cmd   = CMD_SET_NOSPACE;
                    n_state = S_RES;
                end else begin
                    o_cmd   = CMD_NEXT;
                    n_state = S_A_RD;
                end
            end
            S_SP_P: begin
                if (i_status.at_depth) begin
                    o_cmd   = CMD_WR_ALLOC;
                    n_state = S_RES;
                end else begin
                    o_cmd   = CMD_WR_SPLIT;
                    n_state = S_SP_L;
                end
            end
            S_SP_L: begin
                o_cmd   = CMD_WR_LEFT;
                n_state = S_SP_R;
            end
            S_SP_R: begin
                o_cmd   = CMD_WR_RIGHT;
                n_state = S_SP_P;
            end
            S_F_RD: begin
                o_cmd   = CMD_RD_NODE;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (i_status.rd_alloc) begin
                    o_cmd   = CMD_WR_FREE;
                    n_state = S_F_B;
                end else begin
                    o_cmd   = CMD_SET_BADFREE;
                    n_state = S_RES;
                end
            end
            // Merge loop: read the buddy, and fold both into the parent while the buddy is free.
            S_F_B: begin
                if (i_status.at_root) begin
                    n_state = S_RES;
                end else begin
                    o_cmd   = CMD_RD_BUDDY;
                    n_state = S_F_BCHK;
                end
            end
            S_F_BCHK: begin
                if (i_status.rd_free) begin
                    o_cmd   = CMD_WR_ABS_NODE;
                    n_state = S_M_B;
                end else begin
                    n_state = S_RES;
                end
            end
            S_M_B: begin
                o_cmd   = CMD_WR_ABS_BUDDY;
                n_state = S_M_P;
            end
            S_M_P: begin
                o_cmd   = CMD_WR_PARENT;
                n_state = S_F_B;
            end
            S_RES: begin
                if (!i_status.out_busy) begin
                    o_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/buddy_memory_allocator.sv @@
// Buddy allocator over a 1024-unit memory.
// Input channel (i_in_valid, o_in_stall, i_in_data): one transaction is one
// request, either an allocation of request_size units or a free of the block
// at free_address. Output channel (o_out_valid, i_out_stall, o_out_data): one
// transaction per request with status, block address and block size.
// Requests are handled one at a time by a sequencer that walks the node
// store, which has one registered read port and one write port. An allocation
// scans nodes for a free one and then splits it down to the requested size;
// a free checks the node and then merges it with free buddies. The result
// enters the output register at the end, and the next request is taken the
// cycle after, even while that result is still held. After reset a clearing
// pass writes all 2047 nodes, during which o_in_stall stays high. While the
// receiver stalls, the output register holds its transaction, and a finished
// result waits inside the block until the register is free, so no further
// request is taken meanwhile.
module buddy_memory_allocator import bma_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_bma_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_bma_out o_out_data
);

    t_cmd       cmd;
    t_dp_status dp_status;

    // Sequencer.
    bma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Node store, request registers and output register.
    bma_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
